FILE: rtl/core/bsod_pkg.sv
// Shared types and the box overlap function for the box set overlap detector.
package bsod_pkg;

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TEST = 1'b1;

  // Input item: a reference box load or a probe box test
  typedef struct packed {
    logic              kind;
    logic [3:0]        entry_index;
    logic signed [11:0] box_x;
    logic signed [11:0] box_y;
    logic [10:0]       box_w;
    logic [10:0]       box_h;
    logic              last_probe;
  } box_item_t;

  // Result item of one probe box
  typedef struct packed {
    logic box_hit;
    logic set_hit;
    logic set_done;
  } box_result_t;

  // Stored reference box, 46 bits
  typedef struct packed {
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic [10:0]       w;
    logic [10:0]       h;
  } ref_box_t;

  localparam int unsigned RefBoxWidth = $bits(ref_box_t);

  // Boxes overlap unless one edge separates them; touching edges do not count
  function automatic logic boxes_overlap(ref_box_t a, ref_box_t b);
    logic signed [12:0] la;
    logic signed [12:0] ra;
    logic signed [12:0] ta;
    logic signed [12:0] ba;
    logic signed [12:0] lb;
    logic signed [12:0] rb;
    logic signed [12:0] tb;
    logic signed [12:0] bb;
    la = 13'(a.x);
    ta = 13'(a.y);
    ra = la + $signed({2'b00, a.w});
    ba = ta + $signed({2'b00, a.h});
    lb = 13'(b.x);
    tb = 13'(b.y);
    rb = lb + $signed({2'b00, b.w});
    bb = tb + $signed({2'b00, b.h});
    return !((ba <= tb) || (ta >= bb) || (ra <= lb) || (la >= rb));
  endfunction

endpackage

FILE: rtl/core/box_set_overlap_detector.sv
// Top level of the box set overlap detector: reference table, scan sequencer, result register.
//
// Keeps up to MAX_REF_BOXES reference boxes in a synchronous RAM. A load item
// writes one entry in the cycle it is accepted. A test item scans entries
// 0 .. n-1, where n is ref_count limited to MAX_REF_BOXES, reading one entry
// per cycle from the single RAM read port; it occupies the block through setup,
// the n reads, the read latency, closing the scan and the result hand-off, and
// with n zero it goes from setup straight to closing the scan and the hand-off.
// A held result register adds its stall time. The result goes to an output
// register, so the next item is taken while a result waits. Each test item
// yields one result; set_hit is the OR of all hits since the last test item
// marked last_probe and is reported, then cleared, on that item. Entries that
// were never loaded must not be covered by ref_count.
module box_set_overlap_detector
  import bsod_pkg::*;
#(
  parameter int unsigned MAX_REF_BOXES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        probe_valid,
  output logic        probe_stall,
  input  box_item_t   probe_item,
  output logic        result_valid,
  input  logic        result_stall,
  output box_result_t result_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  localparam int unsigned AW = (MAX_REF_BOXES > 1) ? $clog2(MAX_REF_BOXES) : 1;
  localparam int unsigned CW = $clog2(MAX_REF_BOXES + 1);
  localparam int unsigned NW = (CW > 5) ? CW : 5;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]    state;
  logic [4:0]    ref_count;
  ref_box_t      probe;
  logic          last_q;
  logic [CW-1:0] scan_len;
  logic [CW-1:0] issue_cnt;
  logic          rd_pend;
  logic          hit_acc;
  logic          any_hit;

  logic          accept;
  logic          load_we;
  logic [NW-1:0] count_ext;
  logic [NW-1:0] count_sat;
  logic          rd_en;
  logic [RefBoxWidth-1:0] rd_word;
  ref_box_t      entry;
  logic          out_load;
  logic          hit_final;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      ref_count <= cfg_data;
    end
  end

  // Accept items only between scans
  assign probe_stall = (state != S_IDLE);
  assign accept      = probe_valid && !probe_stall;
  assign load_we     = accept && (probe_item.kind == KIND_LOAD)
                       && (NW'(probe_item.entry_index) < NW'(MAX_REF_BOXES));

  // Limit the scan length to the table depth
  assign count_ext = NW'(ref_count);
  assign count_sat = (count_ext > NW'(MAX_REF_BOXES)) ? NW'(MAX_REF_BOXES) : count_ext;

  // Issue one table read per scan cycle until scan_len entries are read
  assign rd_en = (state == S_SCAN) && (issue_cnt < scan_len);

  bsod_ram #(
    .WIDTH(RefBoxWidth),
    .DEPTH(MAX_REF_BOXES)
  ) u_ref_ram (
    .clk  (clk),
    .we   (load_we),
    .waddr(AW'(probe_item.entry_index)),
    .wdata({probe_item.box_x, probe_item.box_y, probe_item.box_w, probe_item.box_h}),
    .re   (rd_en),
    .raddr(issue_cnt[AW-1:0]),
    .rdata(rd_word)
  );

  assign entry     = ref_box_t'(rd_word);
  assign out_load  = (state == S_FIN) && (!result_valid || !result_stall);
  assign hit_final = hit_acc;

  // Scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          rd_pend <= 1'b0;
          if (accept && (probe_item.kind == KIND_TEST)) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pend <= rd_en;
          if (!rd_en && !rd_pend) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          rd_pend <= 1'b0;
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state   <= S_IDLE;
          rd_pend <= 1'b0;
        end
      endcase
    end
  end

  // Latch the probe box and advance the scan
  always_ff @(posedge clk) begin
    if (accept && (probe_item.kind == KIND_TEST)) begin
      probe     <= {probe_item.box_x, probe_item.box_y, probe_item.box_w, probe_item.box_h};
      last_q    <= probe_item.last_probe;
      scan_len  <= CW'(count_sat);
      issue_cnt <= '0;
      hit_acc   <= 1'b0;
    end else if (state == S_SCAN) begin
      if (rd_en) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
      if (rd_pend && boxes_overlap(probe, entry)) begin
        hit_acc <= 1'b1;
      end
    end
  end

  // Sticky set flag: report and clear on the last probe
  always_ff @(posedge clk) begin
    if (rst) begin
      any_hit <= 1'b0;
    end else if (out_load) begin
      if (last_q) begin
        any_hit <= 1'b0;
      end else if (hit_final) begin
        any_hit <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_item.box_hit  <= hit_final;
      result_item.set_hit  <= last_q && (any_hit || hit_final);
      result_item.set_done <= last_q;
    end
  end

  // Results appear only after a finished scan
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_FIN)
    else $error("result raised without a finished scan");

  // Reads stay inside the scan length
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (issue_cnt < scan_len) && (scan_len <= CW'(MAX_REF_BOXES)))
    else $error("table read beyond scan length");

  // A set hit is only reported with set_done
  a_set_hit_done: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!result_item.set_hit || result_item.set_done))
    else $error("set_hit without set_done");

  // A box hit on the last probe forces the set hit
  a_box_implies_set: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_item.set_done && result_item.box_hit) |-> result_item.set_hit)
    else $error("box hit lost from set result");

  // The sticky flag clears once the last probe's result is loaded
  a_sticky_clear: assert property (@(posedge clk) disable iff (rst)
    (out_load && last_q) |=> !any_hit)
    else $error("sticky hit flag not cleared");

endmodule

FILE: rtl/core/bsod_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bsod_ram #(
  parameter int unsigned WIDTH = 46,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read word
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: tb/box_set_overlap_detector_tb.sv
// Self-checking testbench for the box set overlap detector.
module box_set_overlap_detector_tb
  import bsod_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableDepth = 16;
  localparam int DrainCycles = 25;
  localparam int HoldCycles = 300;

  typedef struct {
    int x;
    int y;
    int w;
    int h;
  } box_geom_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        probe_valid = 1'b0;
  logic        probe_stall;
  box_item_t   probe_item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  box_result_t result_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;

  // Predictor state
  box_geom_t   ref_boxes_m [TableDepth];
  bit          entry_loaded [TableDepth];
  bit          sticky_hit = 1'b0;
  int          cur_ref_count = 0;
  box_result_t pending_results [$];

  int          err_count = 0;
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;
  logic        holding = 1'b0;

  box_set_overlap_detector dut (
    .clk          (clk),
    .rst          (rst),
    .probe_valid  (probe_valid),
    .probe_stall  (probe_stall),
    .probe_item   (probe_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Drive the receiver stall: long hold-off or random idling
  always @(posedge clk) begin
    result_stall <= holding || (sink_idle_en && ($urandom_range(0, 99) < 13));
  end

  function automatic box_geom_t item_geom(box_item_t it);
    box_geom_t g;
    g.x = $signed(it.box_x);
    g.y = $signed(it.box_y);
    g.w = it.box_w;
    g.h = it.box_h;
    return g;
  endfunction

  // Touching edges do not count as overlap
  function automatic bit geom_overlap(box_geom_t p, box_geom_t e);
    return !((p.y + p.h <= e.y) || (p.y >= e.y + e.h) ||
             (p.x + p.w <= e.x) || (p.x >= e.x + e.w));
  endfunction

  // Update the table or queue the result of one accepted item
  function automatic void predict_overlap(box_item_t it);
    box_geom_t   probe;
    box_result_t r;
    bit          hit;
    int          n;
    probe = item_geom(it);
    hit = 1'b0;
    if (it.kind == KIND_LOAD) begin
      ref_boxes_m[it.entry_index] = probe;
      entry_loaded[it.entry_index] = 1'b1;
      return;
    end
    n = (cur_ref_count > TableDepth) ? TableDepth : cur_ref_count;
    for (int i = 0; i < n; i++) begin
      if (!entry_loaded[i]) begin
        $display("%0t: test scans entry %0d before it was loaded", $time, i);
        err_count++;
      end
      if (geom_overlap(probe, ref_boxes_m[i])) hit = 1'b1;
    end
    r.box_hit = hit;
    r.set_done = it.last_probe;
    r.set_hit = 1'b0;
    if (it.last_probe) begin
      r.set_hit = sticky_hit | hit;
      sticky_hit = 1'b0;
    end else if (hit) begin
      sticky_hit = 1'b1;
    end
    pending_results.push_back(r);
  endfunction

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    box_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none, actual %b", $time, result_item);
      end else begin
        want = pending_results.pop_front();
        if (result_item.box_hit !== want.box_hit) begin
          err_count++;
          $display("%0t: box_hit expected %0b actual %0b", $time,
                   want.box_hit, result_item.box_hit);
        end
        if (result_item.set_hit !== want.set_hit) begin
          err_count++;
          $display("%0t: set_hit expected %0b actual %0b", $time,
                   want.set_hit, result_item.set_hit);
        end
        if (result_item.set_done !== want.set_done) begin
          err_count++;
          $display("%0t: set_done expected %0b actual %0b", $time,
                   want.set_done, result_item.set_done);
        end
      end
    end
  end

  function automatic box_item_t make_item(logic kind, int idx, int x, int y, int w, int h,
                                          logic last);
    box_item_t it;
    it.kind = kind;
    it.entry_index = idx[3:0];
    it.box_x = x[11:0];
    it.box_y = y[11:0];
    it.box_w = w[10:0];
    it.box_h = h[10:0];
    it.last_probe = last;
    return it;
  endfunction

  // Clustered boxes hit often; wide ones span the full field ranges
  function automatic box_item_t rand_item(logic kind, logic last, bit wide);
    int x;
    int y;
    int w;
    int h;
    if (wide) begin
      x = int'($urandom_range(0, 4095)) - 2048;
      y = int'($urandom_range(0, 4095)) - 2048;
      w = $urandom_range(0, 2047);
      h = $urandom_range(0, 2047);
    end else begin
      x = int'($urandom_range(0, 200)) - 100;
      y = int'($urandom_range(0, 200)) - 100;
      w = $urandom_range(0, 60);
      h = $urandom_range(0, 60);
    end
    return make_item(kind, $urandom_range(0, 15), x, y, w, h, last);
  endfunction

  // Offer one item, holding it until accepted
  task automatic send_item(box_item_t it);
    if (src_idle_en) begin
      while ($urandom_range(0, 99) < 13) begin
        probe_valid <= 1'b0;
        @(posedge clk);
      end
    end
    probe_valid <= 1'b1;
    probe_item <= it;
    do @(posedge clk); while (probe_stall);
    predict_overlap(it);
  endtask

  // Drop valid and wait for every result plus the load latency
  task automatic wait_idle();
    probe_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_ref_count(int value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value[4:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_ref_count = value;
  endtask

  // One load burst followed by a probe set closed by last_probe
  task automatic send_probe_set(int max_loads, int max_probes, int wide_pct);
    int n_loads;
    int n_probes;
    n_loads = $urandom_range(0, max_loads);
    n_probes = $urandom_range(1, max_probes);
    repeat (n_loads)
      send_item(rand_item(KIND_LOAD, $urandom_range(0, 1), $urandom_range(0, 99) < wide_pct));
    for (int i = 0; i < n_probes; i++)
      send_item(rand_item(KIND_TEST, i == n_probes - 1, $urandom_range(0, 99) < wide_pct));
  endtask

  // Empty scan: nothing loaded yet, ref_count still zero from reset
  task automatic test_empty_table();
    send_item(make_item(KIND_TEST, 15, -2048, 2047, 2047, 0, 1'b0));
    send_item(make_item(KIND_TEST, 0, 0, 0, 2047, 2047, 1'b1));
  endtask

  // Touching edges, zero-size probes and a one-pixel overlap against entry 0
  task automatic test_edge_cases();
    send_item(make_item(KIND_LOAD, 0, 0, 0, 10, 10, 1'b1));
    write_ref_count(1);
    send_item(make_item(KIND_TEST, 0, 10, 0, 5, 5, 1'b0));
    send_item(make_item(KIND_TEST, 0, -5, 0, 5, 5, 1'b0));
    send_item(make_item(KIND_TEST, 0, 0, 10, 5, 5, 1'b0));
    send_item(make_item(KIND_TEST, 0, 0, -5, 5, 5, 1'b1));
    send_item(make_item(KIND_TEST, 0, 9, 9, 1, 1, 1'b0));
    send_item(make_item(KIND_TEST, 0, 5, 0, 0, 10, 1'b0));
    send_item(make_item(KIND_TEST, 0, 0, 5, 0, 0, 1'b0));
    send_item(make_item(KIND_TEST, 0, -2048, -2048, 2047, 2047, 1'b1));
  endtask

  // Fill the table, then scan it with a count beyond the table size
  task automatic test_saturated_count();
    box_item_t it;
    send_item(make_item(KIND_LOAD, 1, -2048, -2048, 2047, 2047, 1'b0));
    send_item(make_item(KIND_LOAD, 15, 2047, 2047, 2047, 2047, 1'b1));
    for (int i = 2; i < 15; i++) begin
      it = rand_item(KIND_LOAD, 1'b0, 1'b1);
      it.entry_index = i[3:0];
      send_item(it);
    end
    write_ref_count(31);
    send_item(make_item(KIND_TEST, 7, 2047, 2047, 2047, 2047, 1'b0));
    send_item(make_item(KIND_TEST, 3, -2048, -2048, 1, 1, 1'b0));
    send_item(make_item(KIND_TEST, 0, 1000, -1500, 0, 0, 1'b1));
  endtask

  // Well-formed probe sets over several ref_count settings
  task automatic test_probe_sets();
    int counts [10] = '{16, 1, 5, 0, 17, 8, 3, 12, 31, 16};
    foreach (counts[i]) begin
      write_ref_count(counts[i]);
      repeat (24) send_probe_set(3, 6, 10);
    end
  endtask

  // Long stretch with neither side idling
  task automatic test_no_idle();
    write_ref_count(4);
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    repeat (50) send_probe_set(2, 6, 10);
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // Hold the result side off while items keep arriving
  task automatic test_backpressure();
    write_ref_count(2);
    src_idle_en = 1'b0;
    fork
      begin
        holding <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        holding <= 1'b0;
      end
      repeat (60) send_item(rand_item(KIND_TEST, $urandom_range(0, 1), 1'b0));
    join
    src_idle_en = 1'b1;
  endtask

  // Unstructured mix of loads and tests
  task automatic test_noise();
    write_ref_count($urandom_range(0, 31));
    repeat (300)
      send_item(rand_item($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1)));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_edge_cases();
    test_saturated_count();
    test_probe_sets();
    test_no_idle();
    test_backpressure();
    test_noise();
    wait_idle();
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("PASS box_set_overlap_detector");
    end else begin
      $display("FAIL box_set_overlap_detector");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #8ms;
    $display("FAIL box_set_overlap_detector");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/bsod_pkg.sv
rtl/core/bsod_ram.sv
rtl/core/box_set_overlap_detector.sv
tb/box_set_overlap_detector_tb.sv
